// ===== design/dsf_pkg.sv =====
// Shared types and constants for the duplicate sequence filter.
package dsf_pkg;

	localparam int ADDR_W  = 48;
	localparam int SEQ_W   = 16;
	localparam int ENTRY_W = ADDR_W + SEQ_W;

	// Operation codes carried in the op field
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] src_addr;
		logic [SEQ_W-1:0]  seq_num;
	} dsf_req_t;

	typedef struct packed {
		logic is_new;
		logic table_full;
	} dsf_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OUT
	} dsf_state_t;

endpackage

// ===== design/dsf_stream_if.sv =====
// Valid/ready stream interface used for the request and response channels.
interface dsf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/duplicate_sequence_filter.sv =====
// Top level of the duplicate sequence filter: table walker and result register.
//
// Usage:
//   req carries one beat per frame: op (check or clear), src_addr, seq_num.
//   rsp returns one beat per request: is_new and table_full.
//   The table holds up to TABLE_DEPTH (address, last sequence) entries in one
//   RAM; a single comparator walks the valid entries in fill order, one entry
//   per cycle, using the RAM's one registered read port.
//   Response: a clear, or a check against an empty table, goes from idle
//   straight to the response state, valid in the cycle after the request beat.
//   Any other check first walks the scan state, comparing k entries, where
//   1 <= k <= current fill, and then moves to the response state.
//   Requests are taken one at a time; req.ready is high only while idle, so
//   a new request waits until the response beat is accepted and the walker
//   is back in idle.
//   Reset (arst_n low) empties the table at once by zeroing the fill count;
//   no clearing pass is needed, only entries below the fill count are read.
//   If the receiver stalls, the response holds on rsp and no new request is
//   taken until that beat is accepted.
module duplicate_sequence_filter
	import dsf_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	dsf_stream_if.sink   req,
	dsf_stream_if.source rsp
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	dsf_state_t         state_q, state_d;
	logic [CNT_W-1:0]   fill_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [SEQ_W-1:0]   seq_q;
	dsf_rsp_t           res_q;

	logic               req_acc;
	logic               rsp_acc;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic [ADDR_W-1:0]  ent_addr;
	logic [SEQ_W-1:0]   ent_seq;
	logic [CNT_W-1:0]   idx_inc;
	logic               hit;
	logic               last;
	logic               done;
	logic               fill_inc;
	dsf_rsp_t           res_d;

	assign req_acc   = req.valid && req.ready;
	assign rsp_acc   = rsp.valid && rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.data  = res_q;

	assign ent_addr = ram_rdata[ENTRY_W-1:SEQ_W];
	assign ent_seq  = ram_rdata[SEQ_W-1:0];
	assign idx_inc  = {1'b0, idx_q} + CNT_W'(1);
	assign hit      = (ent_addr == addr_q);
	assign last     = (idx_inc == fill_q);

	dsf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: next state, table access and result
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {addr_q, seq_q};
		ram_re    = 1'b0;
		ram_raddr = '0;
		done      = 1'b0;
		fill_inc  = 1'b0;
		res_d     = '0;
		unique case (state_q)
			ST_IDLE: begin
				// For a check, start reading the first entry with the request beat
				ram_re    = req_acc && (req.data.op == OP_CHECK);
				ram_raddr = '0;
				if (req_acc) begin
					if (req.data.op == OP_CLEAR) begin
						state_d = ST_OUT;
					end else if (fill_q == '0) begin
						// Empty table: append at slot zero
						ram_we    = 1'b1;
						ram_waddr = '0;
						ram_wdata = {req.data.src_addr, req.data.seq_num};
						fill_inc  = 1'b1;
						res_d     = '{is_new: 1'b1, table_full: 1'b0};
						state_d   = ST_OUT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ram_raddr = idx_inc[IDX_W-1:0];
				priority if (hit) begin
					done = 1'b1;
					if (seq_q > ent_seq) begin
						ram_we    = 1'b1;
						ram_waddr = idx_q;
						res_d     = '{is_new: 1'b1, table_full: 1'b0};
					end
				end else if (last) begin
					// Unknown source: append if there is room, else flag table_full
					done  = 1'b1;
					if (fill_q < FULL_CNT) begin
						ram_we    = 1'b1;
						ram_waddr = fill_q[IDX_W-1:0];
						fill_inc  = 1'b1;
						res_d     = '{is_new: 1'b1, table_full: 1'b0};
					end else begin
						res_d = '{is_new: 1'b1, table_full: 1'b1};
					end
				end else begin
					ram_re = 1'b1;
				end
				if (done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (rsp_acc) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (req_acc && (req.data.op == OP_CLEAR)) begin
				fill_q <= '0;
			end else if (fill_inc) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (req_acc) begin
				idx_q <= '0;
			end else if ((state_q == ST_SCAN) && !done) begin
				idx_q <= idx_inc[IDX_W-1:0];
			end
		end
	end

	// Request payload and result registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			addr_q <= req.data.src_addr;
			seq_q  <= req.data.seq_num;
		end
		if (req_acc || ((state_q == ST_SCAN) && done)) begin
			res_q <= res_d;
		end
	end

	// Fill count never exceeds the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count above table depth");

	// The walker only visits valid entries
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, idx_q} < fill_q))
		else $error("scan index beyond fill count");

	// A clear empties the table by the next cycle
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.data.op == OP_CLEAR)) |=> (fill_q == '0))
		else $error("clear did not empty table");

	// A full flag only comes with a full table and a new frame
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.table_full) |-> (rsp.data.is_new && (fill_q == FULL_CNT)))
		else $error("table_full without full table");

	// No request is taken while a response waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while response pending");

endmodule

// ===== design/dsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dsf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
